>>> rtl/ddrpg_pkg.sv
// ddrpg_pkg: shared types and constants for the differential drive ramp packet generator.
// No dependencies; imported by diff_drive_ramp_packet_gen.
package ddrpg_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROD,
		ST_STEP_DIV,
		ST_RAMP,
		ST_TURN,
		ST_MIX,
		ST_CMD_DIV,
		ST_EMIT
	} ddrpg_state_t;

	// field widths
	localparam int CFG_W   = 15;
	localparam int ADDR_W  = 8;
	localparam int IDX_W   = 3;
	localparam int TGT_W   = 16;
	localparam int TIME_W  = 32;
	localparam int DT_W    = 7;
	localparam int PROD_W  = 22;   // accel * dt, 15 x 7 bits
	localparam int STEP_W  = 12;   // max step 3276
	localparam int REM_W   = 10;   // remainder of divide by 1000
	localparam int MAG_W   = 7;
	localparam int QUO_W   = 8;    // wheel quotient, top bit flags overflow
	localparam int CNT_W   = 5;
	localparam int Q_SHIFT = 12;   // Q4.12

	// register indexes
	localparam logic [IDX_W-1:0] REG_MAX_LIN    = 3'd0;
	localparam logic [IDX_W-1:0] REG_MAX_ANG    = 3'd1;
	localparam logic [IDX_W-1:0] REG_LIN_ACCEL  = 3'd2;
	localparam logic [IDX_W-1:0] REG_ANG_ACCEL  = 3'd3;
	localparam logic [IDX_W-1:0] REG_HALF_TRACK = 3'd4;
	localparam logic [IDX_W-1:0] REG_FRONT_ADDR = 3'd5;
	localparam logic [IDX_W-1:0] REG_REAR_ADDR  = 3'd6;

	// register reset values
	localparam logic [CFG_W-1:0]  RST_MAX_LIN    = 15'd6144;
	localparam logic [CFG_W-1:0]  RST_MAX_ANG    = 15'd8192;
	localparam logic [CFG_W-1:0]  RST_LIN_ACCEL  = 15'd8192;
	localparam logic [CFG_W-1:0]  RST_ANG_ACCEL  = 15'd16384;
	localparam logic [CFG_W-1:0]  RST_HALF_TRACK = 15'd2048;
	localparam logic [ADDR_W-1:0] RST_FRONT_ADDR = 8'd128;
	localparam logic [ADDR_W-1:0] RST_REAR_ADDR  = 8'd129;

	localparam logic [TIME_W-1:0] DT_CAP_MS = 32'd100;
	localparam logic [REM_W:0]    MS_PER_S  = 11'd1000;
	localparam logic [MAG_W-1:0]  FULL_CMD  = 7'd127;

	// motor command codes
	localparam logic [2:0] CMD_LEFT_FWD  = 3'd0;
	localparam logic [2:0] CMD_RIGHT_FWD = 3'd4;
	localparam logic [2:0] CMD_REV       = 3'd1;

	// byte position inside a packet
	localparam logic [1:0] BYTE_ADDR = 2'd0;
	localparam logic [1:0] BYTE_CMD  = 2'd1;
	localparam logic [1:0] BYTE_MAG  = 2'd2;
	localparam logic [1:0] BYTE_SUM  = 2'd3;

	// last count of each serial phase
	localparam logic [CNT_W-1:0] DIV_LAST  = 5'd21;
	localparam logic [CNT_W-1:0] TURN_LAST = 5'd14;
	localparam logic [CNT_W-1:0] CMD_LAST  = 5'd7;
	localparam logic [CNT_W-1:0] EMIT_LAST = 5'd15;

endpackage

>>> rtl/diff_drive_ramp_packet_gen.sv
// diff_drive_ramp_packet_gen: slew-limited differential drive mixer emitting motor packets.
// Depends on ddrpg_pkg (state type, register indexes, command codes).

// A drive word on the slave stream carries target linear and angular speed (Q4.12) and a
// millisecond timestamp; tuser set marks a safety stop. Each accepted word produces sixteen
// bytes on the master stream: four 4-byte packets (front left, front right, rear left,
// rear right) of address, command, magnitude and 7-bit checksum, tlast on the sixteenth.
// The datapath is serial: the per-axis step accel*dt/1000 comes out of a radix-2 divider
// one quotient bit per cycle, the turn term ang*half_track is a shift-add over half_track
// one bit per cycle, and the wheel scaling *127/max_linear is a radix-2 divider giving
// one command bit per cycle. A drive word passes through acceptance, product, step divide,
// ramp, turn, mix, command divide and the sixteen bytes before the next acceptance; a
// stop word goes from acceptance straight to the bytes. One word is processed at a time;
// the final byte sits in the output register while the next word is taken. Configuration
// writes are taken every cycle and belong to idle periods.
module diff_drive_ramp_packet_gen import ddrpg_pkg::*; #(
	parameter int SPEED_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	// slave stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [63:0]       s_tdata,    // [15:0] target_lin, [31:16] target_ang, [63:32] now_ms
	input  logic [0:0]        s_tuser,    // [0] func (1 = stop)
	// master stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,    // [7:0] tx_byte
	output logic              m_tlast,    // last_byte
	// configuration writes
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int SW    = SPEED_WIDTH;
	localparam int RW    = ((SW > TGT_W) ? SW : TGT_W) + 2;  // ramp arithmetic width
	localparam int TW    = SW + CFG_W;                       // ang * half_track
	localparam int QW    = SW + 16;                          // wheel value, Q8.24
	localparam int NW    = QW - 5;                           // |wheel|*127 >> 12
	localparam int DVS_W = CFG_W + MAG_W;                    // max_lin << 7
	localparam int CW    = (NW > DVS_W) ? NW : DVS_W;        // wheel divider width

	localparam logic signed [RW-1:0] SPD_MAX = $signed({{(RW-SW+1){1'b0}}, {(SW-1){1'b1}}});
	localparam logic signed [RW-1:0] SPD_MIN = ~SPD_MAX;

	ddrpg_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	// configuration
	logic [CFG_W-1:0]  max_lin_q, max_ang_q, lin_acc_q, ang_acc_q, half_track_q;
	logic [ADDR_W-1:0] front_addr_q, rear_addr_q;

	// architectural state
	logic [TIME_W-1:0]      last_time_q;
	logic signed [SW-1:0]   lin_q, ang_q;

	// per-word working registers
	logic signed [TGT_W-1:0] tl_q, ta_q;
	logic [DT_W-1:0]         dt_q;
	logic [REM_W-1:0]        sl_rem_q, sa_rem_q;
	logic [PROD_W-1:0]       sl_quo_q, sa_quo_q;
	logic signed [TW-1:0]    turn_q;
	logic [CFG_W-1:0]        ht_sh_q;
	logic [CW-1:0]           rem_l_q, rem_r_q, dvs_q;
	logic [QUO_W-1:0]        quo_l_q, quo_r_q;
	logic                    neg_l_q, neg_r_q;

	// output register
	logic              m_tvalid_q;
	logic [7:0]        m_tdata_q;
	logic              m_tlast_q;

	logic accept, out_load;

	// ------------------------------------------------------------------
	// helpers
	// ------------------------------------------------------------------
	function automatic logic signed [TGT_W-1:0] clamp_sym(logic signed [TGT_W-1:0] v,
			logic [CFG_W-1:0] lim);
		logic signed [TGT_W:0] vx, lp, ln;
		vx = {v[TGT_W-1], v};
		lp = $signed({2'b00, lim});
		ln = -lp;
		if (vx > lp) return lp[TGT_W-1:0];
		else if (vx < ln) return ln[TGT_W-1:0];
		else return v;
	endfunction

	// move cur toward tgt by at most step, then saturate to the speed range
	function automatic logic signed [SW-1:0] ramp_sat(logic signed [SW-1:0] cur,
			logic signed [TGT_W-1:0] tgt, logic [STEP_W-1:0] step);
		logic signed [RW-1:0] c, t, s, e, r;
		c = RW'(cur);
		t = RW'(tgt);
		s = $signed({{(RW-STEP_W){1'b0}}, step});
		e = t - c;
		if (e > s) r = c + s;
		else if (e < -s) r = c - s;
		else r = t;
		if (r > SPD_MAX) r = SPD_MAX;
		else if (r < SPD_MIN) r = SPD_MIN;
		return r[SW-1:0];
	endfunction

	// floor(|q|*127 / 4096), dividend of the wheel divider
	function automatic logic [CW-1:0] wheel_num(logic signed [QW-1:0] q);
		logic [QW-1:0]   m;
		logic [QW+6:0]   p;
		m = q[QW-1] ? (~q + 1'b1) : q;
		p = {m, 7'b0} - {7'b0, m};
		return CW'(p[QW+6:Q_SHIFT]);
	endfunction

	// ------------------------------------------------------------------
	// datapath logic
	// ------------------------------------------------------------------
	logic [TIME_W-1:0]  dt_raw;
	logic [DT_W-1:0]    dt_cap;
	logic [PROD_W-1:0]  p_lin, p_ang;
	logic [REM_W:0]     trial_l, trial_a;
	logic               ge_sl, ge_sa;
	logic signed [TW-1:0] turn_nx;
	logic signed [QW-1:0] lin4k, turn_x, wl, wr;
	logic [CFG_W-1:0]   dv;
	logic               ge_l, ge_r;
	logic [MAG_W-1:0]   mag_l, mag_r, mag_sel;
	logic               neg_sel, right, rear;
	logic [2:0]         cmd_sel;
	logic [ADDR_W-1:0]  addr_sel, sum_sel, byte_sel;

	assign dt_raw = s_tdata[63:32] - last_time_q;
	assign dt_cap = (dt_raw > DT_CAP_MS) ? DT_CAP_MS[DT_W-1:0] : dt_raw[DT_W-1:0];

	assign p_lin = {{(PROD_W-CFG_W){1'b0}}, lin_acc_q} * {{(PROD_W-DT_W){1'b0}}, dt_q};
	assign p_ang = {{(PROD_W-CFG_W){1'b0}}, ang_acc_q} * {{(PROD_W-DT_W){1'b0}}, dt_q};

	// divide by 1000, one quotient bit a cycle
	assign trial_l = {sl_rem_q, sl_quo_q[PROD_W-1]};
	assign trial_a = {sa_rem_q, sa_quo_q[PROD_W-1]};
	assign ge_sl   = trial_l >= MS_PER_S;
	assign ge_sa   = trial_a >= MS_PER_S;

	// shift-add over half_track, MSB first
	assign turn_nx = {turn_q[TW-2:0], 1'b0} + (ht_sh_q[CFG_W-1] ? TW'(ang_q) : '0);

	assign lin4k  = QW'(lin_q) <<< Q_SHIFT;
	assign turn_x = QW'(turn_q);
	assign wl     = lin4k - turn_x;
	assign wr     = lin4k + turn_x;

	assign dv   = (max_lin_q == '0) ? CFG_W'(1) : max_lin_q;
	assign ge_l = rem_l_q >= dvs_q;
	assign ge_r = rem_r_q >= dvs_q;

	// packet byte selection; quotient top bit set means the command saturates
	assign mag_l    = quo_l_q[QUO_W-1] ? FULL_CMD : quo_l_q[MAG_W-1:0];
	assign mag_r    = quo_r_q[QUO_W-1] ? FULL_CMD : quo_r_q[MAG_W-1:0];
	assign right    = cnt_q[2];
	assign rear     = cnt_q[3];
	assign mag_sel  = right ? mag_r : mag_l;
	assign neg_sel  = right ? neg_r_q : neg_l_q;
	assign cmd_sel  = (right ? CMD_RIGHT_FWD : CMD_LEFT_FWD)
			| ((neg_sel && (mag_sel != '0)) ? CMD_REV : 3'd0);
	assign addr_sel = rear ? rear_addr_q : front_addr_q;
	assign sum_sel  = addr_sel + {5'b0, cmd_sel} + {1'b0, mag_sel};

	always_comb begin
		case (cnt_q[1:0])
			BYTE_ADDR: byte_sel = addr_sel;
			BYTE_CMD:  byte_sel = {5'b0, cmd_sel};
			BYTE_MAG:  byte_sel = {1'b0, mag_sel};
			BYTE_SUM:  byte_sel = {1'b0, sum_sel[6:0]};
			default:   byte_sel = addr_sel;
		endcase
	end

	// ------------------------------------------------------------------
	// control
	// ------------------------------------------------------------------
	assign accept    = s_tvalid && s_tready;
	assign out_load  = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tlast   = m_tlast_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		s_tready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = s_tuser[0] ? ST_EMIT : ST_PROD;
			end
			ST_PROD: state_d = ST_STEP_DIV;
			ST_STEP_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = ST_RAMP;
					cnt_d   = '0;
				end else cnt_d = cnt_q + 1'b1;
			end
			ST_RAMP: state_d = ST_TURN;
			ST_TURN: begin
				if (cnt_q == TURN_LAST) begin
					state_d = ST_MIX;
					cnt_d   = '0;
				end else cnt_d = cnt_q + 1'b1;
			end
			ST_MIX: state_d = ST_CMD_DIV;
			ST_CMD_DIV: begin
				if (cnt_q == CMD_LAST) begin
					state_d = ST_EMIT;
					cnt_d   = '0;
				end else cnt_d = cnt_q + 1'b1;
			end
			ST_EMIT: begin
				if (out_load) begin
					if (cnt_q == EMIT_LAST) begin
						state_d = ST_IDLE;
						cnt_d   = '0;
					end else cnt_d = cnt_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// configuration, speeds, timestamp, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_lin_q    <= RST_MAX_LIN;
			max_ang_q    <= RST_MAX_ANG;
			lin_acc_q    <= RST_LIN_ACCEL;
			ang_acc_q    <= RST_ANG_ACCEL;
			half_track_q <= RST_HALF_TRACK;
			front_addr_q <= RST_FRONT_ADDR;
			rear_addr_q  <= RST_REAR_ADDR;
			last_time_q  <= '0;
			lin_q        <= '0;
			ang_q        <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_MAX_LIN:    max_lin_q    <= cfg_data;
					REG_MAX_ANG:    max_ang_q    <= cfg_data;
					REG_LIN_ACCEL:  lin_acc_q    <= cfg_data;
					REG_ANG_ACCEL:  ang_acc_q    <= cfg_data;
					REG_HALF_TRACK: half_track_q <= cfg_data;
					REG_FRONT_ADDR: front_addr_q <= cfg_data[ADDR_W-1:0];
					REG_REAR_ADDR:  rear_addr_q  <= cfg_data[ADDR_W-1:0];
					default: ;
				endcase
			end
			// stop leaves the timestamp alone
			if (accept && !s_tuser[0]) last_time_q <= s_tdata[63:32];
			if (accept && s_tuser[0]) begin
				lin_q <= '0;
				ang_q <= '0;
			end else if (state_q == ST_RAMP) begin
				lin_q <= ramp_sat(lin_q, tl_q, sl_quo_q[STEP_W-1:0]);
				ang_q <= ramp_sat(ang_q, ta_q, sa_quo_q[STEP_W-1:0]);
			end
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// serial datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					tl_q    <= clamp_sym(s_tdata[15:0], max_lin_q);
					ta_q    <= clamp_sym(s_tdata[31:16], max_ang_q);
					dt_q    <= dt_cap;
					quo_l_q <= '0;
					quo_r_q <= '0;
					neg_l_q <= 1'b0;
					neg_r_q <= 1'b0;
				end
			end
			ST_PROD: begin
				sl_quo_q <= p_lin;
				sa_quo_q <= p_ang;
				sl_rem_q <= '0;
				sa_rem_q <= '0;
			end
			ST_STEP_DIV: begin
				sl_rem_q <= ge_sl ? REM_W'(trial_l - MS_PER_S) : trial_l[REM_W-1:0];
				sa_rem_q <= ge_sa ? REM_W'(trial_a - MS_PER_S) : trial_a[REM_W-1:0];
				sl_quo_q <= {sl_quo_q[PROD_W-2:0], ge_sl};
				sa_quo_q <= {sa_quo_q[PROD_W-2:0], ge_sa};
			end
			ST_RAMP: begin
				turn_q  <= '0;
				ht_sh_q <= half_track_q;
			end
			ST_TURN: begin
				turn_q  <= turn_nx;
				ht_sh_q <= {ht_sh_q[CFG_W-2:0], 1'b0};
			end
			ST_MIX: begin
				rem_l_q <= wheel_num(wl);
				rem_r_q <= wheel_num(wr);
				neg_l_q <= wl[QW-1];
				neg_r_q <= wr[QW-1];
				dvs_q   <= CW'({dv, {MAG_W{1'b0}}});
			end
			ST_CMD_DIV: begin
				rem_l_q <= ge_l ? (rem_l_q - dvs_q) : rem_l_q;
				rem_r_q <= ge_r ? (rem_r_q - dvs_q) : rem_r_q;
				quo_l_q <= {quo_l_q[QUO_W-2:0], ge_l};
				quo_r_q <= {quo_r_q[QUO_W-2:0], ge_r};
				dvs_q   <= dvs_q >> 1;
			end
			ST_EMIT: begin
				if (out_load) begin
					m_tdata_q <= byte_sel;
					m_tlast_q <= (cnt_q == EMIT_LAST);
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_accept_cnt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (cnt_q == '0))
		else $error("byte counter not cleared at word acceptance");

	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser[0]) |=> (lin_q == '0) && (ang_q == '0) && (state_q == ST_EMIT))
		else $error("stop word did not clear speeds");

	a_time_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && !s_tuser[0]) |=> $stable(last_time_q))
		else $error("timestamp changed without a drive word");

	a_divisor_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMD_DIV) |-> (dvs_q != '0))
		else $error("wheel divisor shifted out");

endmodule
